// ----- rtl/core/minl1_pkg.sv -----
// shared types and constants for the min l1 distance block
`default_nettype none

package minl1_pkg;

  // parameter defaults
  localparam int DEF_MAX_REFERENCES = 64;
  localparam int DEF_MAX_LENGTH     = 64;
  localparam int DEF_VALUE_BITS     = 10;

  // fixed field widths
  localparam int KIND_W     = 2;
  localparam int VALUE_W    = 10;
  localparam int ACC_BITS   = 16;
  localparam int VL_W       = 7;
  localparam int VC_W       = 10;
  localparam int CFG_DATA_W = 10;
  localparam int CFG_IDX_W  = 1;

  localparam logic [ACC_BITS-1:0] ACC_MAX = '1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VECTOR_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_VOTER_COUNT   = 1'b1;

  localparam logic [VL_W-1:0] VECTOR_LENGTH_RESET = 7'd64;
  localparam logic [VC_W-1:0] VOTER_COUNT_RESET   = 10'd1023;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic               last;
  } in_req_t;

  typedef struct packed {
    logic [ACC_BITS-1:0] min_distance;
    logic                set_empty;
    logic                length_overflow;
  } out_rsp_t;

  // broadcast controls from the sequencer to every cell
  typedef struct packed {
    logic wr;         // write the store row of the selected cell
    logic load_done;  // selected cell becomes a reference, clear its sum
    logic rd;         // read the store at the query index
    logic acc;        // add the distance of the element read last cycle
    logic clr_all;    // zero all sums
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/minl1_cell.sv -----
// one reference cell: store row, running l1 sum and a stage of the min chain
`default_nettype none

module minl1_cell #(
  parameter int IDX            = 0,
  parameter int MAX_REFERENCES = minl1_pkg::DEF_MAX_REFERENCES,
  parameter int MAX_LENGTH     = minl1_pkg::DEF_MAX_LENGTH,
  parameter int VALUE_BITS     = minl1_pkg::DEF_VALUE_BITS,
  localparam int CNT_W         = $clog2(MAX_REFERENCES + 1),
  localparam int AW            = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  minl1_pkg::cell_ctl_t          ctl,
  input  logic [CNT_W-1:0]              ref_count,
  input  logic [AW-1:0]                 addr,
  input  logic [VALUE_BITS-1:0]         wdata,
  input  logic [VALUE_BITS-1:0]         qval,
  input  logic [minl1_pkg::ACC_BITS-1:0] min_in,
  output logic [minl1_pkg::ACC_BITS-1:0] min_out
);

  import minl1_pkg::*;

  logic [VALUE_BITS-1:0] ref_mem [MAX_LENGTH];
  logic [VALUE_BITS-1:0] rd_r;
  logic [ACC_BITS-1:0]   acc_r;
  logic [ACC_BITS-1:0]   acc_nxt;
  logic [ACC_BITS-1:0]   min_r;
  logic [ACC_BITS-1:0]   min_nxt;
  logic [VALUE_BITS-1:0] diff;
  logic [ACC_BITS:0]     sum;
  logic                  sel;
  logic                  active;

  assign sel    = (ref_count == CNT_W'(IDX));
  assign active = (CNT_W'(IDX) < ref_count);

  // row store, registered read
  always_ff @(posedge clk) begin
    if (ctl.wr && sel) begin
      ref_mem[addr] <= wdata;
    end
    if (ctl.rd) begin
      rd_r <= ref_mem[addr];
    end
  end

  always_comb begin
    diff = (qval >= rd_r) ? (qval - rd_r) : (rd_r - qval);
    sum  = {1'b0, acc_r} + (ACC_BITS + 1)'(diff);
    acc_nxt = acc_r;
    if (ctl.clr_all || (ctl.load_done && sel)) begin
      acc_nxt = '0;
    end else if (ctl.acc && active) begin
      acc_nxt = sum[ACC_BITS] ? ACC_MAX : sum[ACC_BITS-1:0];
    end
    min_nxt = (active && (acc_r < min_in)) ? acc_r : min_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  // running minimum handed on to the next cell every cycle
  always_ff @(posedge clk) begin
    min_r <= min_nxt;
  end

  assign min_out = min_r;

endmodule

`default_nettype wire

// ----- rtl/core/min_l1_distance_to_set.sv -----
// top level: nearest reference by l1 distance over a chain of reference cells
// timing: load and clear requests are handled in idle; a query element is read from the
//   cell stores, then accumulated in S_ACC; after the last query element the min ripples
//   down the cell chain in S_SWEEP, then S_DONE loads the output register
// throughput: 1 load or clear per cycle while idle; requests stall while a query is busy
// reset: control, sums and config return to defaults; the store is not cleared
`default_nettype none

module min_l1_distance_to_set #(
  parameter int MAX_REFERENCES = minl1_pkg::DEF_MAX_REFERENCES,
  parameter int MAX_LENGTH     = minl1_pkg::DEF_MAX_LENGTH,
  parameter int VALUE_BITS     = minl1_pkg::DEF_VALUE_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // request channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  minl1_pkg::in_req_t               in_data,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output minl1_pkg::out_rsp_t              out_data,
  // configuration writes
  input  logic                             cfg_we,
  input  logic [minl1_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [minl1_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  import minl1_pkg::*;

  localparam int CNT_W = $clog2(MAX_REFERENCES + 1);   // reference count
  localparam int LW    = $clog2(MAX_LENGTH + 1);       // element indexes
  localparam int AW    = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int SW_W  = (MAX_REFERENCES > 1) ? $clog2(MAX_REFERENCES) : 1;
  localparam logic [SW_W-1:0] SWEEP_LAST = SW_W'(MAX_REFERENCES - 1);
  localparam int PROD_W = LW + VC_W + 1;

  typedef enum logic [1:0] {
    S_IDLE,   // taking requests
    S_ACC,    // cells add the distance of the element just read
    S_SWEEP,  // min ripples down the chain
    S_DONE    // result ready, waiting for the output register
  } state_t;

  // configuration registers
  logic [VL_W-1:0] vector_length_r;
  logic [VC_W-1:0] voter_count_r;

  // sequencer state
  state_t          state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [LW-1:0]   lidx_r, lidx_nxt;
  logic [LW-1:0]   qidx_r, qidx_nxt;
  logic            ovf_r, ovf_nxt;
  logic            pend_r, pend_nxt;
  logic            last_r, last_nxt;
  logic [SW_W-1:0] sweep_r, sweep_nxt;
  logic            out_valid_r, out_valid_nxt;

  // payload registers
  logic [VALUE_BITS-1:0] qval_r, qval_nxt;
  out_rsp_t              out_data_r, out_data_nxt;
  logic [ACC_BITS-1:0]   sentinel_r;

  logic [LW-1:0]         len;
  logic [15:0]           value_ext;
  logic [VALUE_BITS-1:0] in_val;
  logic [PROD_W-1:0]     sent_full;
  logic                  in_acc;
  cell_ctl_t             ctl;
  logic [AW-1:0]         addr;
  logic [ACC_BITS-1:0]   min_chain [MAX_REFERENCES + 1];

  // only the low VALUE_BITS bits of an element count
  assign value_ext = 16'(in_data.value);
  assign in_val    = value_ext[VALUE_BITS-1:0];

  // effective length, capped by the store depth
  assign len = (11'(vector_length_r) >= 11'(MAX_LENGTH)) ? LW'(MAX_LENGTH)
                                                          : LW'(vector_length_r);

  // sentinel len*voters+1, saturated to the sum width; registered, as the user must write
  // config only while idle (the block itself does not enforce this)
  assign sent_full = PROD_W'(len) * PROD_W'(voter_count_r) + PROD_W'(1);

  always_ff @(posedge clk) begin
    sentinel_r <= (sent_full > PROD_W'(ACC_MAX)) ? ACC_MAX : sent_full[ACC_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vector_length_r <= VECTOR_LENGTH_RESET;
      voter_count_r   <= VOTER_COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VECTOR_LENGTH: vector_length_r <= cfg_wdata[VL_W-1:0];
        REG_VOTER_COUNT:   voter_count_r   <= cfg_wdata[VC_W-1:0];
        default: ;
      endcase
    end
  end

  // requests are taken only while the sequencer waits in idle
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    lidx_nxt      = lidx_r;
    qidx_nxt      = qidx_r;
    ovf_nxt       = ovf_r;
    pend_nxt      = pend_r;
    last_nxt      = last_r;
    sweep_nxt     = sweep_r;
    qval_nxt      = qval_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    ctl           = '0;
    addr          = qidx_r[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_data.kind)
            KIND_LOAD: begin
              // a full set drops further load elements
              if (cnt_r < CNT_W'(MAX_REFERENCES)) begin
                addr   = lidx_r[AW-1:0];
                ctl.wr = (lidx_r < len);
                if (lidx_r < LW'(MAX_LENGTH)) begin
                  lidx_nxt = lidx_r + LW'(1);
                end
                if (in_data.last) begin
                  ctl.load_done = 1'b1;
                  cnt_nxt       = cnt_r + CNT_W'(1);
                  lidx_nxt      = '0;
                end
              end
            end
            KIND_QUERY: begin
              ctl.rd   = (qidx_r < len);
              pend_nxt = (qidx_r < len);
              qval_nxt = in_val;
              last_nxt = in_data.last;
              // element past the vector length adds nothing but is flagged
              if (!(qidx_r < len)) begin
                ovf_nxt = 1'b1;
              end
              if (qidx_r < LW'(MAX_LENGTH)) begin
                qidx_nxt = qidx_r + LW'(1);
              end
              state_nxt = S_ACC;
            end
            KIND_CLEAR: begin
              // query in progress keeps its index and overflow flag
              cnt_nxt     = '0;
              lidx_nxt    = '0;
              ctl.clr_all = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_ACC: begin
        ctl.acc   = pend_r;
        sweep_nxt = '0;
        state_nxt = last_r ? S_SWEEP : S_IDLE;
      end
      S_SWEEP: begin
        // step the sweep count across the cells until the chain tail holds the minimum
        if (sweep_r == SWEEP_LAST) begin
          state_nxt = S_DONE;
        end else begin
          sweep_nxt = sweep_r + SW_W'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.min_distance    = min_chain[MAX_REFERENCES];
          out_data_nxt.set_empty       = (cnt_r == '0);
          out_data_nxt.length_overflow = ovf_r;
          ctl.clr_all = 1'b1;
          qidx_nxt    = '0;
          ovf_nxt     = 1'b0;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      lidx_r      <= '0;
      qidx_r      <= '0;
      ovf_r       <= 1'b0;
      pend_r      <= 1'b0;
      last_r      <= 1'b0;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      lidx_r      <= lidx_nxt;
      qidx_r      <= qidx_nxt;
      ovf_r       <= ovf_nxt;
      pend_r      <= pend_nxt;
      last_r      <= last_nxt;
      sweep_r     <= sweep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    qval_r     <= qval_nxt;
    out_data_r <= out_data_nxt;
  end

  // chain of cells; the head is seeded with the sentinel
  assign min_chain[0] = sentinel_r;

  for (genvar i = 0; i < MAX_REFERENCES; i++) begin : g_cell
    minl1_cell #(
      .IDX            (i),
      .MAX_REFERENCES (MAX_REFERENCES),
      .MAX_LENGTH     (MAX_LENGTH),
      .VALUE_BITS     (VALUE_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .ref_count (cnt_r),
      .addr      (addr),
      .wdata     (in_val),
      .qval      (qval_r),
      .min_in    (min_chain[i]),
      .min_out   (min_chain[i+1])
    );
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// self-checking bench for min_l1_distance_to_set: load, query and clear traffic
module testbench;
  import minl1_pkg::*;

  localparam int REFS         = DEF_MAX_REFERENCES;
  localparam int COLS         = DEF_MAX_LENGTH;
  // min ripples through one cell per reference, then on through the output register to the port
  localparam int DRAIN_CYCLES = REFS + 40;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 143;

  // code the block ignores
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  // predictor of the nearest-reference search plus the queue of answers it owes
  class nearest_ref_scoreboard;
    logic [VALUE_W-1:0] store [REFS*COLS];
    bit                 written [REFS*COLS];
    int unsigned        ref_count;
    int unsigned        load_pos;
    int unsigned        query_pos;
    int unsigned        sums [REFS];
    bit                 overflow;
    logic [VL_W-1:0]    vec_len;
    logic [VC_W-1:0]    voters;
    out_rsp_t           expected [$];
    int                 errors;

    function new();
      vec_len = VECTOR_LENGTH_RESET;
      voters  = VOTER_COUNT_RESET;
    endfunction

    function int unsigned active_len();
      return (vec_len < COLS) ? vec_len : COLS;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_VECTOR_LENGTH) vec_len = data[VL_W-1:0];
      else voters = data[VC_W-1:0];
    endfunction

    // next query element would touch a store column never loaded
    function bit reads_unwritten();
      if (query_pos >= active_len()) return 1'b0;
      for (int r = 0; r < ref_count; r++) begin
        if (!written[r*COLS + query_pos]) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_request(in_req_t rq);
      int unsigned len;
      int unsigned best;
      int unsigned ref_val;
      int unsigned diff;
      out_rsp_t    rsp;
      len = active_len();
      case (rq.kind)
        KIND_LOAD: begin
          // a full set drops the element entirely
          if (ref_count < REFS) begin
            if (load_pos < len) begin
              store[ref_count*COLS + load_pos]   = rq.value;
              written[ref_count*COLS + load_pos] = 1'b1;
            end
            if (load_pos < COLS) load_pos++;
            if (rq.last) begin
              sums[ref_count] = 0;
              ref_count++;
              load_pos = 0;
            end
          end
        end
        KIND_CLEAR: begin
          // query in progress keeps its index and overflow flag
          ref_count = 0;
          load_pos  = 0;
          foreach (sums[r]) sums[r] = 0;
        end
        KIND_QUERY: begin
          if (query_pos < len) begin
            for (int r = 0; r < ref_count; r++) begin
              ref_val = store[r*COLS + query_pos];
              diff    = (rq.value >= ref_val) ? rq.value - ref_val : ref_val - rq.value;
              sums[r] = (sums[r] + diff > ACC_MAX) ? ACC_MAX : sums[r] + diff;
            end
          end else begin
            overflow = 1'b1;
          end
          if (query_pos < COLS) query_pos++;
          if (rq.last) begin
            best = len * voters + 1;
            if (best > ACC_MAX) best = ACC_MAX;
            for (int r = 0; r < ref_count; r++) begin
              if (sums[r] < best) best = sums[r];
            end
            rsp.min_distance    = best[ACC_BITS-1:0];
            rsp.set_empty       = (ref_count == 0);
            rsp.length_overflow = overflow;
            expected.push_back(rsp);
            foreach (sums[r]) sums[r] = 0;
            query_pos = 0;
            overflow  = 1'b0;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(out_rsp_t got);
      out_rsp_t want;
      if (expected.size() == 0) begin
        $display("%0t: result with none expected: min_distance %0d set_empty %0b overflow %0b",
                 $time, got.min_distance, got.set_empty, got.length_overflow);
        errors++;
        return;
      end
      want = expected.pop_front();
      if (got.min_distance !== want.min_distance) begin
        $display("%0t: min_distance expected %0d got %0d",
                 $time, want.min_distance, got.min_distance);
        errors++;
      end
      if (got.set_empty !== want.set_empty) begin
        $display("%0t: set_empty expected %0b got %0b", $time, want.set_empty, got.set_empty);
        errors++;
      end
      if (got.length_overflow !== want.length_overflow) begin
        $display("%0t: length_overflow expected %0b got %0b",
                 $time, want.length_overflow, got.length_overflow);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_req_t               in_data;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_rsp_t              out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  nearest_ref_scoreboard sb;
  idle_mode_t            idle_mode   = IDLE_NONE;
  logic                  hold_active = 1'b0;
  event                  start_hold;
  int unsigned           live_items;

  min_l1_distance_to_set u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // receiver side: random stall per idling mode, forced high during a long hold
  always @(negedge clk) begin
    case (idle_mode)
      IDLE_RECEIVER: out_stall <= hold_active || ($urandom_range(0, 99) < 50);
      IDLE_BOTH:     out_stall <= hold_active || ($urandom_range(0, 99) < 7);
      default:       out_stall <= hold_active;
    endcase
  end

  // long receiver hold, counted here so the sender keeps pushing requests meanwhile
  initial begin
    forever begin
      @(start_hold);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(negedge clk);
      hold_active <= 1'b0;
    end
  end

  // result monitor: every accepted answer goes to the scoreboard
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // sender idle cycles ahead of a request
  task automatic idle_gap();
    int gap;
    int pct;
    gap = 0;
    pct = (idle_mode == IDLE_SENDER) ? 50 : (idle_mode == IDLE_BOTH) ? 7 : 0;
    while (gap < 12 && $urandom_range(0, 99) < pct) gap++;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // offer one request and hold it until the block takes it
  task automatic send(logic [KIND_W-1:0] kind, logic [VALUE_W-1:0] value, logic last);
    in_req_t rq;
    rq.kind  = kind;
    rq.value = value;
    rq.last  = last;
    idle_gap();
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= rq;
    do @(posedge clk); while (in_stall);
    // ignored codes and loads into a full set do not count toward the workload
    if (kind != KIND_UNUSED && !(kind == KIND_LOAD && sb.ref_count >= REFS)) live_items++;
    sb.note_request(rq);
  endtask

  // query element; a stored row with unloaded columns must never be read,
  // so such a set is dropped just before the element
  task automatic send_query(logic [VALUE_W-1:0] value, logic last);
    if (sb.reads_unwritten()) begin
      send(KIND_CLEAR, VALUE_W'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
    end
    send(KIND_QUERY, value, last);
  endtask

  // stop offering, let every owed answer arrive, then let the cell chain go quiet
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // both registers back to back, write enable held across the pair
  task automatic set_config(int unsigned vlen, int unsigned voters);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_VECTOR_LENGTH;
    cfg_wdata <= CFG_DATA_W'(vlen);
    @(negedge clk);
    cfg_index <= REG_VOTER_COUNT;
    cfg_wdata <= CFG_DATA_W'(voters);
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(REG_VECTOR_LENGTH, CFG_DATA_W'(vlen));
    sb.set_reg(REG_VOTER_COUNT, CFG_DATA_W'(voters));
  endtask

  // one setting: mostly whole reference loads and whole queries with random content,
  // plus clears, ignored codes, loads slipped into queries and odd vector lengths
  task automatic run_phase(int unsigned vlen, int unsigned voters, idle_mode_t mode,
                           int unsigned quota, bit hold);
    int unsigned len;
    int unsigned n;
    int unsigned first_item;
    int unsigned pick;
    int unsigned r;
    int unsigned v;
    settle();
    set_config(vlen, voters);
    idle_mode  = mode;
    if (hold) -> start_hold;
    len        = sb.active_len();
    first_item = live_items;
    while (live_items - first_item < quota) begin
      pick = $urandom_range(0, 99);
      n    = (len == 0) ? 1 : len;
      if ($urandom_range(0, 9) == 0) n = n + $urandom_range(1, 3);
      else if ($urandom_range(0, 9) == 0) n = $urandom_range(1, n);
      if (pick < 35) begin
        for (int i = 0; i < n; i++) begin
          send(KIND_LOAD, VALUE_W'($urandom_range(0, 1023)), i == n - 1);
        end
      end else if (pick < 85) begin
        for (int i = 0; i < n; i++) begin
          // now and then a reference load lands in the middle of a query
          if (i > 0 && $urandom_range(0, 19) == 0) begin
            send(KIND_LOAD, VALUE_W'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
          end
          v = $urandom_range(0, 1023);
          if ($urandom_range(0, 1) == 0) v = $urandom_range(0, voters);
          // steer toward a stored row so small distances show up
          if (sb.ref_count > 0 && sb.query_pos < len && $urandom_range(0, 1) == 1) begin
            r = $urandom_range(0, sb.ref_count - 1);
            if (sb.written[r*COLS + sb.query_pos]) begin
              v = sb.store[r*COLS + sb.query_pos] + $urandom_range(0, 3);
              if (v > 1023) v = 1023;
            end
          end
          send_query(VALUE_W'(v), i == n - 1);
        end
      end else if (pick < 92) begin
        send(KIND_CLEAR, VALUE_W'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
      end else begin
        send(KIND_UNUSED, VALUE_W'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
      end
    end
    // close an open query so the setting changes with no query pending
    if (sb.query_pos != 0) send_query(VALUE_W'($urandom_range(0, 1023)), 1'b1);
  endtask

  initial begin
    sb         = new();
    live_items = 0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty set under reset settings gives the full sentinel; ignored code
    send_query(10'd0, 1'b1);
    send(KIND_UNUSED, 10'h3ff, 1'b1);

    settle();
    set_config(2, 1023);
    // two references at opposite extremes
    send(KIND_LOAD, 10'd0, 1'b0);
    send(KIND_LOAD, 10'd1023, 1'b1);
    send(KIND_LOAD, 10'd1023, 1'b0);
    send(KIND_LOAD, 10'd0, 1'b1);
    // exact match, distance zero
    send_query(10'd0, 1'b0);
    send_query(10'd1023, 1'b1);
    // long query raises the overflow flag
    send_query(10'd1023, 1'b0);
    send_query(10'd1023, 1'b0);
    send_query(10'd0, 1'b1);
    // long reference, element past the length is dropped
    send(KIND_LOAD, 10'd512, 1'b0);
    send(KIND_LOAD, 10'd1, 1'b0);
    send(KIND_LOAD, 10'd1023, 1'b1);
    // short query, missing element adds nothing
    send_query(10'd512, 1'b1);
    // reference completes mid query and only sees the later elements
    send_query(10'd100, 1'b0);
    send(KIND_LOAD, 10'd7, 1'b0);
    send(KIND_LOAD, 10'd8, 1'b1);
    send_query(10'd8, 1'b1);
    // clear, then a query against the empty set
    send(KIND_CLEAR, 10'd0, 1'b0);
    send_query(10'd3, 1'b0);
    send_query(10'd4, 1'b1);

    // random part across settings and idling modes
    run_phase(3,   1023, IDLE_NONE,     PHASE_ITEMS, 1'b0);
    run_phase(1,   0,    IDLE_SENDER,   PHASE_ITEMS, 1'b0);
    run_phase(4,   500,  IDLE_RECEIVER, PHASE_ITEMS, 1'b0);
    run_phase(2,   1023, IDLE_BOTH,     PHASE_ITEMS, 1'b0);
    run_phase(64,  1023, IDLE_NONE,     PHASE_ITEMS, 1'b0);
    // zero length: every element overflows and the sentinel is one
    run_phase(0,   1,    IDLE_SENDER,   PHASE_ITEMS, 1'b0);
    run_phase(127, 1023, IDLE_RECEIVER, PHASE_ITEMS, 1'b0);
    // long receiver hold with the sender running flat out
    run_phase(5,   1023, IDLE_NONE,     PHASE_ITEMS, 1'b1);
    run_phase(8,   3,    IDLE_BOTH,     PHASE_ITEMS, 1'b0);
    // short vectors fill the set past its capacity
    run_phase(1,   1023, IDLE_RECEIVER, PHASE_ITEMS, 1'b0);

    settle();
    if (sb.errors == 0 && sb.expected.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #8000000;
    $display("%0t: timeout with %0d answers outstanding", $time, sb.expected.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
